/* hw/rtl/rovc_pkg.sv */
// Shared types, codes and sizes for the rover obstacle and waypoint controller.
`default_nettype none

package rovc_pkg;

  localparam int MAX_WAYPOINTS = 16;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int ADDR_W        = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  // request queue between front and back; depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int SONAR_W = 12;
  localparam int COUNT_W = 8;
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int DIST_W  = 20;
  localparam int ANGLE_W = 13;

  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 + 1 + 3 + LAT_W + LON_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [SONAR_W-1:0] VERY_NEAR_RST   = 12'd5;
  localparam logic [SONAR_W-1:0] NEAR_RST        = 12'd60;
  localparam logic [SONAR_W-1:0] SIDE_MED_RST    = 12'd120;
  localparam logic [SONAR_W-1:0] CENTER_MED_RST  = 12'd140;
  localparam logic [SONAR_W-1:0] REAR_MED_RST    = 12'd100;
  localparam logic [DIST_W-1:0]  REACH_DIST_RST  = 20'd48;
  localparam logic [DIST_W-1:0]  FINAL_STOP_RST  = 20'd32;

  // angles in sixteenths of a degree
  localparam int ANG_SLIGHT = 7 * 16;
  localparam int ANG_90     = 90 * 16;
  localparam int ANG_180    = 180 * 16;
  localparam int ANG_270    = 270 * 16;
  localparam int ANG_353    = 353 * 16;
  localparam int ANG_FULL   = 360 * 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_SONAR    = 3'd1,
    CMD_COUNT    = 3'd2,
    CMD_WAYPOINT = 3'd3,
    CMD_COMPASS  = 3'd4,
    CMD_START    = 3'd5,
    CMD_STOP     = 3'd6
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERY_NEAR  = 3'd0,
    CFG_NEAR       = 3'd1,
    CFG_SIDE_MED   = 3'd2,
    CFG_CENTER_MED = 3'd3,
    CFG_REAR_MED   = 3'd4,
    CFG_REACH_DIST = 3'd5,
    CFG_FINAL_STOP = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SPD_STOP    = 2'd0,
    SPD_SLOW    = 2'd1,
    SPD_NORMAL  = 2'd2,
    SPD_REVERSE = 2'd3
  } speed_e;

  typedef enum logic {
    DIR_FWD  = 1'b0,
    DIR_BACK = 1'b1
  } dir_e;

  typedef enum logic [2:0] {
    TURN_STRAIGHT     = 3'd0,
    TURN_SLIGHT_LEFT  = 3'd1,
    TURN_SLIGHT_RIGHT = 3'd2,
    TURN_HARD_LEFT    = 3'd3,
    TURN_HARD_RIGHT   = 3'd4
  } turn_e;

  typedef enum logic [1:0] {
    OP_MOTOR = 2'd0,
    OP_POINT = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // one queued request: a motor command, a waypoint report or a store write
  typedef struct packed {
    op_e               op;
    speed_e            speed;
    dir_e              dir;
    turn_e             turn;
    logic              last;
    logic              zero;
    logic [ADDR_W-1:0] addr;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
  } rec_t;

  typedef struct packed {
    logic vld0;
    logic vld1;
    rec_t rec0;
    rec_t rec1;
  } q_push_t;

endpackage

`default_nettype wire

/* hw/rtl/rovc_queue.sv */
// Short request queue between front and back: two pushes and one pop a cycle.
`default_nettype none

module rovc_queue import rovc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    room2,
  input  logic    pop,
  output logic    rd_valid,
  output rec_t    rd_rec
);

  rec_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign room2    = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_rec   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.vld0) + QPTR_W'(push.vld1);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.vld0) + QCNT_W'(push.vld1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      ent_r[wr_ptr_r] <= push.rec0;
    end
    if (push.vld1) begin
      ent_r[wr_ptr_r + QPTR_W'(1)] <= push.rec1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rovc_front.sv */
// Front end: decodes events, keeps vehicle state, runs avoidance and steering decisions.
`default_nettype none

module rovc_front import rovc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  cmd_e                  cmd,
  input  logic [SONAR_W-1:0]    sonar_left,
  input  logic [SONAR_W-1:0]    sonar_center,
  input  logic [SONAR_W-1:0]    sonar_right,
  input  logic [SONAR_W-1:0]    sonar_rear,
  input  logic [COUNT_W-1:0]    point_count,
  input  logic [LAT_W-1:0]      latitude,
  input  logic [LON_W-1:0]      longitude,
  input  logic [DIST_W-1:0]     distance,
  input  logic [ANGLE_W-1:0]    bearing,
  input  logic [ANGLE_W-1:0]    heading,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output q_push_t               push
);

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_SEND = 2'd1,
    MODE_NAV  = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RNG_VNEAR = 2'd0,
    RNG_NEAR  = 2'd1,
    RNG_MED   = 2'd2,
    RNG_FAR   = 2'd3
  } range_e;

  localparam int DIFF_W = ANGLE_W + 2;
  localparam logic signed [DIFF_W-1:0] S_SLIGHT = DIFF_W'(ANG_SLIGHT);
  localparam logic signed [DIFF_W-1:0] S_90     = DIFF_W'(ANG_90);
  localparam logic signed [DIFF_W-1:0] S_180    = DIFF_W'(ANG_180);
  localparam logic signed [DIFF_W-1:0] S_270    = DIFF_W'(ANG_270);
  localparam logic signed [DIFF_W-1:0] S_353    = DIFF_W'(ANG_353);
  localparam logic signed [DIFF_W-1:0] S_FULL   = DIFF_W'(ANG_FULL);

  function automatic range_e classify(input logic [SONAR_W-1:0] v,
                                      input logic [SONAR_W-1:0] vn,
                                      input logic [SONAR_W-1:0] nr,
                                      input logic [SONAR_W-1:0] med);
    if (v <= vn) return RNG_VNEAR;
    if (v <= nr) return RNG_NEAR;
    if (v <= med) return RNG_MED;
    return RNG_FAR;
  endfunction

  function automatic rec_t mk_motor(input speed_e s, input dir_e d, input turn_e t);
    rec_t r;
    r       = '0;
    r.op    = OP_MOTOR;
    r.speed = s;
    r.dir   = d;
    r.turn  = t;
    return r;
  endfunction

  // configuration
  logic [SONAR_W-1:0] very_near_r, near_r, side_med_r, center_med_r, rear_med_r;
  logic [DIST_W-1:0]  reach_dist_r, final_stop_r;

  // vehicle state
  mode_e              mode_r, mode_nxt;
  logic               avoid_r, avoid_nxt;
  logic [SONAR_W-1:0] son_l_r, son_c_r, son_r_r, son_b_r;
  logic [SONAR_W-1:0] son_l_nxt, son_c_nxt, son_r_nxt, son_b_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [ANGLE_W-1:0] bear_r, bear_nxt, head_r, head_nxt;
  logic [IDX_W-1:0]   total_r, total_nxt, fill_r, fill_nxt, target_r, target_nxt;

  range_e lr, cr, rr, br;
  logic   front_block;
  logic   av_hit;
  rec_t   av_rec;
  rec_t   steer_rec;
  logic signed [DIFF_W-1:0] diff, wrapped;

  assign lr = classify(son_l_r, very_near_r, near_r, side_med_r);
  assign cr = classify(son_c_r, very_near_r, near_r, center_med_r);
  assign rr = classify(son_r_r, very_near_r, near_r, side_med_r);
  assign br = classify(son_b_r, very_near_r, near_r, rear_med_r);
  assign front_block = (cr == RNG_NEAR) || (lr == RNG_NEAR && rr == RNG_NEAR);

  // avoidance table, first match wins
  always_comb begin
    av_hit = 1'b1;
    av_rec = mk_motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT);
    priority if (front_block && br != RNG_FAR) begin
      av_rec = mk_motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT);
    end else if (front_block) begin
      av_rec = mk_motor(SPD_REVERSE, DIR_BACK,
                        (son_l_r < son_r_r) ? TURN_SLIGHT_LEFT : TURN_SLIGHT_RIGHT);
    end else if (lr == RNG_MED && rr == RNG_FAR) begin
      av_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_RIGHT);
    end else if (lr == RNG_FAR && rr == RNG_MED) begin
      av_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_LEFT);
    end else if (lr == RNG_NEAR) begin
      av_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_HARD_RIGHT);
    end else if (rr == RNG_NEAR) begin
      av_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_HARD_LEFT);
    end else if (lr == RNG_MED || cr == RNG_MED || rr == RNG_MED) begin
      av_rec = mk_motor(SPD_NORMAL, DIR_FWD, TURN_STRAIGHT);
    end else begin
      av_hit = 1'b0;
    end
  end

  // steering by bearing minus heading, wrapped once; still negative steers straight
  assign diff    = $signed({2'b00, bear_r}) - $signed({2'b00, head_r});
  assign wrapped = diff[DIFF_W-1] ? (diff + S_FULL) : diff;

  always_comb begin
    priority if (wrapped > S_SLIGHT && wrapped <= S_90) begin
      steer_rec = mk_motor(SPD_NORMAL, DIR_FWD, TURN_SLIGHT_RIGHT);
    end else if (wrapped > S_90 && wrapped <= S_180) begin
      steer_rec = mk_motor(SPD_NORMAL, DIR_FWD, TURN_HARD_RIGHT);
    end else if (wrapped > S_180 && wrapped <= S_270) begin
      steer_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_HARD_LEFT);
    end else if (wrapped > S_270 && wrapped <= S_353) begin
      steer_rec = mk_motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_LEFT);
    end else begin
      steer_rec = mk_motor(SPD_NORMAL, DIR_FWD, TURN_STRAIGHT);
    end
  end

  always_comb begin
    logic [1:0] n;
    logic       clear;
    rec_t       stop_rec;
    rec_t       pt_rec;
    rec_t       wr_rec;

    n        = 2'd0;
    clear    = avoid_r && !av_hit;
    stop_rec = mk_motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT);

    pt_rec      = '0;
    pt_rec.op   = OP_POINT;
    pt_rec.addr = target_r[ADDR_W-1:0];
    pt_rec.zero = (target_r == IDX_W'(MAX_WAYPOINTS));

    wr_rec      = '0;
    wr_rec.op   = OP_WRITE;
    wr_rec.addr = fill_r[ADDR_W-1:0];
    wr_rec.lat  = latitude;
    wr_rec.lon  = longitude;

    mode_nxt   = mode_r;
    avoid_nxt  = avoid_r;
    son_l_nxt  = son_l_r;
    son_c_nxt  = son_c_r;
    son_r_nxt  = son_r_r;
    son_b_nxt  = son_b_r;
    dist_nxt   = dist_r;
    bear_nxt   = bear_r;
    head_nxt   = head_r;
    total_nxt  = total_r;
    fill_nxt   = fill_r;
    target_nxt = target_r;
    push       = '0;

    if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          if (avoid_r && av_hit) begin
            push.rec0 = av_rec;
            n = 2'd1;
          end
          if (mode_r == MODE_NAV && clear) begin
            if (dist_r <= reach_dist_r && target_r < total_r) begin
              mode_nxt = MODE_SEND;
            end else if (dist_r <= final_stop_r && target_r == total_r) begin
              mode_nxt  = MODE_STOP;
              avoid_nxt = 1'b0;
              push.rec0 = stop_rec;
              n = 2'd1;
            end
            if (n == 2'd0) push.rec0 = steer_rec;
            else push.rec1 = steer_rec;
            n = n + 2'd1;
          end else if (mode_r == MODE_SEND) begin
            if (n == 2'd0) push.rec0 = pt_rec;
            else push.rec1 = pt_rec;
            n = n + 2'd1;
          end else if (mode_r == MODE_STOP) begin
            if (n == 2'd0) push.rec0 = stop_rec;
            else push.rec1 = stop_rec;
            n = n + 2'd1;
          end
        end
        CMD_SONAR: begin
          son_l_nxt = sonar_left;
          son_c_nxt = sonar_center;
          son_r_nxt = sonar_right;
          son_b_nxt = sonar_rear;
        end
        CMD_COUNT: begin
          if (32'(point_count) > 32'(MAX_WAYPOINTS)) total_nxt = IDX_W'(MAX_WAYPOINTS);
          else total_nxt = IDX_W'(point_count);
          fill_nxt   = '0;
          target_nxt = '0;
        end
        CMD_WAYPOINT: begin
          // a full store drops the data without effect
          if (fill_r < IDX_W'(MAX_WAYPOINTS)) begin
            push.vld0 = 1'b1;
            push.rec0 = wr_rec;
            fill_nxt  = fill_r + IDX_W'(1);
            if (fill_r + IDX_W'(1) == total_r) mode_nxt = MODE_SEND;
          end
        end
        CMD_COMPASS: begin
          dist_nxt = distance;
          bear_nxt = bearing;
          head_nxt = heading;
          if (mode_r == MODE_SEND) begin
            if (target_r < IDX_W'(MAX_WAYPOINTS)) target_nxt = target_r + IDX_W'(1);
            mode_nxt = MODE_NAV;
          end
        end
        CMD_START: begin
          avoid_nxt = 1'b1;
        end
        CMD_STOP: begin
          mode_nxt  = MODE_STOP;
          avoid_nxt = 1'b0;
          push.rec0 = stop_rec;
          n = 2'd1;
        end
        default: begin
        end
      endcase

      if (n != 2'd0) begin
        push.vld0 = 1'b1;
        push.vld1 = (n == 2'd2);
        if (n == 2'd2) push.rec1.last = 1'b1;
        else push.rec0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_INIT;
      avoid_r  <= 1'b0;
      son_l_r  <= '0;
      son_c_r  <= '0;
      son_r_r  <= '0;
      son_b_r  <= '0;
      dist_r   <= '0;
      bear_r   <= '0;
      head_r   <= '0;
      total_r  <= '0;
      fill_r   <= '0;
      target_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      avoid_r  <= avoid_nxt;
      son_l_r  <= son_l_nxt;
      son_c_r  <= son_c_nxt;
      son_r_r  <= son_r_nxt;
      son_b_r  <= son_b_nxt;
      dist_r   <= dist_nxt;
      bear_r   <= bear_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      fill_r   <= fill_nxt;
      target_r <= target_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      very_near_r  <= VERY_NEAR_RST;
      near_r       <= NEAR_RST;
      side_med_r   <= SIDE_MED_RST;
      center_med_r <= CENTER_MED_RST;
      rear_med_r   <= REAR_MED_RST;
      reach_dist_r <= REACH_DIST_RST;
      final_stop_r <= FINAL_STOP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_VERY_NEAR:  very_near_r  <= cfg_data[SONAR_W-1:0];
        CFG_NEAR:       near_r       <= cfg_data[SONAR_W-1:0];
        CFG_SIDE_MED:   side_med_r   <= cfg_data[SONAR_W-1:0];
        CFG_CENTER_MED: center_med_r <= cfg_data[SONAR_W-1:0];
        CFG_REAR_MED:   rear_med_r   <= cfg_data[SONAR_W-1:0];
        CFG_REACH_DIST: reach_dist_r <= cfg_data[DIST_W-1:0];
        CFG_FINAL_STOP: final_stop_r <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rovc_back.sv */
// Back end: waypoint store, report lookup and the registered result port.
`default_nettype none

module rovc_back import rovc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rec_t                  q_rec,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // speed, travel_dir, turn, out_latitude, out_longitude
  output logic                  out_tuser,   // kind
  output logic                  out_tlast
);

  localparam int WORD_W = LAT_W + LON_W;

  logic [WORD_W-1:0]        wp_mem [MAX_WAYPOINTS];
  logic [MAX_WAYPOINTS-1:0] wp_vld_r;

  logic              s1_valid_r, s1_valid_nxt;
  rec_t              s1_rec_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_ok_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_last_r;
  speed_e           out_speed_r;
  dir_e             out_dir_r;
  turn_e            out_turn_r;
  logic [LAT_W-1:0] out_lat_r;
  logic [LON_W-1:0] out_lon_r;

  logic is_wr, out_free, s1_free, ld_s1, is_pt;

  assign is_wr    = (q_rec.op == OP_WRITE);
  assign out_free = !out_valid_r || out_tready;
  assign s1_free  = !s1_valid_r || out_free;
  // store writes retire at once; results need the lookup stage free
  assign q_pop    = q_valid && (is_wr || s1_free);
  assign ld_s1    = q_valid && !is_wr && s1_free;
  assign is_pt    = (s1_rec_r.op == OP_POINT);

  assign s1_valid_nxt  = s1_free ? (q_valid && !is_wr) : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_vld_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && is_wr) wp_vld_r[q_rec.addr] <= 1'b1;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_wr) begin
      wp_mem[q_rec.addr] <= {q_rec.lat, q_rec.lon};
    end
    if (ld_s1) begin
      s1_rec_r  <= q_rec;
      rd_word_r <= wp_mem[q_rec.addr];
      rd_ok_r   <= wp_vld_r[q_rec.addr] && !q_rec.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_kind_r  <= is_pt;
      out_last_r  <= s1_rec_r.last;
      out_speed_r <= s1_rec_r.speed;
      out_dir_r   <= s1_rec_r.dir;
      out_turn_r  <= s1_rec_r.turn;
      out_lat_r   <= (is_pt && rd_ok_r) ? rd_word_r[WORD_W-1:LON_W] : '0;
      out_lon_r   <= (is_pt && rd_ok_r) ? rd_word_r[LON_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_lon_r, out_lat_r, out_turn_r, out_dir_r,
                       out_speed_r};

endmodule

`default_nettype wire

/* hw/rtl/rover_obstacle_and_waypoint_controller.sv */
// Rover controller top level: front end, request queue and back end.
`default_nettype none

// Takes one event request per cycle while in_tready is high; in_tready drops only when
// the request queue between front and back has fewer than two free slots. A tick may
// give two results; results leave at one per cycle while out_tready is high, so the output
// port sets the sustained rate: one request per cycle when each gives at most one result,
// while a tick that gives two results holds the port for both. A result passes through
// the queue, the waypoint-store read stage and the output register.
// The waypoint store needs no clearing pass: per-entry valid bits clear at reset.
// Configuration writes are taken every cycle and should be made while idle.
module rover_obstacle_and_waypoint_controller import rovc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sonar_left, sonar_center, sonar_right, sonar_rear, point_count, latitude,
  // longitude, distance, bearing, heading
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,    // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // speed, travel_dir, turn, out_latitude, out_longitude
  output logic                  out_tuser,   // kind
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  q_push_t q_push;
  logic    q_room, q_valid, q_pop, accept;
  rec_t    q_rec;

  assign in_tready = q_room;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  rovc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (cmd_e'(in_tuser)),
    .sonar_left   (in_tdata[11:0]),
    .sonar_center (in_tdata[23:12]),
    .sonar_right  (in_tdata[35:24]),
    .sonar_rear   (in_tdata[47:36]),
    .point_count  (in_tdata[55:48]),
    .latitude     (in_tdata[86:56]),
    .longitude    (in_tdata[118:87]),
    .distance     (in_tdata[138:119]),
    .bearing      (in_tdata[151:139]),
    .heading      (in_tdata[164:152]),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (q_push)
  );

  rovc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .room2    (q_room),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  rovc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rec      (q_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // the front only queues work for an accepted request
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld0 |-> (in_tvalid && in_tready))
    else $error("queue push without accepted request");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld1 |-> q_push.vld0)
    else $error("second queue slot pushed alone");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the rover obstacle and waypoint controller.
module tb_top;
  import rovc_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 8;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic        KIND_MOTOR  = 1'b0;
  localparam logic        KIND_POINT  = 1'b1;

  typedef enum logic [1:0] {MODE_INIT, MODE_SEND, MODE_NAV, MODE_STOP} mode_e;
  typedef enum logic [1:0] {RNG_VNEAR, RNG_NEAR, RNG_MED, RNG_FAR} rng_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SONAR_W-1:0] son_l;
    logic [SONAR_W-1:0] son_c;
    logic [SONAR_W-1:0] son_r;
    logic [SONAR_W-1:0] son_b;
    logic [COUNT_W-1:0] point_cnt;
    logic [LAT_W-1:0]   lat;
    logic [LON_W-1:0]   lon;
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] bear;
    logic [ANGLE_W-1:0] head;
  } evt_t;

  typedef struct packed {
    logic             kind;
    speed_e           speed;
    dir_e             dir;
    turn_e            turn;
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic             last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  rover_obstacle_and_waypoint_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller state mirror
  logic [SONAR_W-1:0] vnear_lim  = VERY_NEAR_RST;
  logic [SONAR_W-1:0] near_lim   = NEAR_RST;
  logic [SONAR_W-1:0] side_lim   = SIDE_MED_RST;
  logic [SONAR_W-1:0] center_lim = CENTER_MED_RST;
  logic [SONAR_W-1:0] rear_lim   = REAR_MED_RST;
  logic [DIST_W-1:0]  reach_lim  = REACH_DIST_RST;
  logic [DIST_W-1:0]  final_lim  = FINAL_STOP_RST;

  mode_e              ctl_mode = MODE_INIT;
  logic               avoid_on = 1'b0;
  logic [SONAR_W-1:0] son_mem [4] = '{default: '0};
  logic [DIST_W-1:0]  comp_dist = '0;
  logic [ANGLE_W-1:0] comp_bear = '0;
  logic [ANGLE_W-1:0] comp_head = '0;
  int                 total_pts = 0;
  int                 fill_idx = 0;
  int                 target_idx = 0;
  logic [LAT_W-1:0]   lat_mem [MAX_WAYPOINTS] = '{default: '0};
  logic [LON_W-1:0]   lon_mem [MAX_WAYPOINTS] = '{default: '0};

  evt_t    event_queue [$];
  result_t due_results [$];
  evt_t    cur_evt;
  result_t got_res;
  result_t want_res;
  int      send_idle = 8;
  int      recv_idle = 75;
  int      total_queued = 0;
  int      mismatches = 0;
  int      hold_left = 0;
  logic    hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  function automatic result_t motor(speed_e s, dir_e d, turn_e t);
    result_t r;
    r = '0;
    r.kind = KIND_MOTOR;
    r.speed = s;
    r.dir = d;
    r.turn = t;
    return r;
  endfunction

  function automatic rng_e classify(logic [SONAR_W-1:0] v, logic [SONAR_W-1:0] med);
    if (v <= vnear_lim) return RNG_VNEAR;
    if (v <= near_lim) return RNG_NEAR;
    if (v <= med) return RNG_MED;
    return RNG_FAR;
  endfunction

  // returns 1 when the sonar picture calls for an avoidance command
  function automatic bit avoid_command(output result_t r);
    rng_e lr, cr, rr, br;
    bit   blocked;
    lr = classify(son_mem[0], side_lim);
    cr = classify(son_mem[1], center_lim);
    rr = classify(son_mem[2], side_lim);
    br = classify(son_mem[3], rear_lim);
    blocked = (cr == RNG_NEAR) || (lr == RNG_NEAR && rr == RNG_NEAR);
    avoid_command = 1'b1;
    r = '0;
    if (blocked && br != RNG_FAR) r = motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT);
    else if (blocked)
      r = motor(SPD_REVERSE, DIR_BACK,
                (son_mem[0] < son_mem[2]) ? TURN_SLIGHT_LEFT : TURN_SLIGHT_RIGHT);
    else if (lr == RNG_MED && rr == RNG_FAR) r = motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_RIGHT);
    else if (lr == RNG_FAR && rr == RNG_MED) r = motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_LEFT);
    else if (lr == RNG_NEAR) r = motor(SPD_SLOW, DIR_FWD, TURN_HARD_RIGHT);
    else if (rr == RNG_NEAR) r = motor(SPD_SLOW, DIR_FWD, TURN_HARD_LEFT);
    else if (lr == RNG_MED || cr == RNG_MED || rr == RNG_MED)
      r = motor(SPD_NORMAL, DIR_FWD, TURN_STRAIGHT);
    else avoid_command = 1'b0;
  endfunction

  function automatic result_t steer_command();
    int ang;
    ang = int'(comp_bear) - int'(comp_head);
    if (ang < 0) ang += ANG_FULL;
    if (ang > ANG_SLIGHT && ang <= ANG_90) return motor(SPD_NORMAL, DIR_FWD, TURN_SLIGHT_RIGHT);
    if (ang > ANG_90 && ang <= ANG_180) return motor(SPD_NORMAL, DIR_FWD, TURN_HARD_RIGHT);
    if (ang > ANG_180 && ang <= ANG_270) return motor(SPD_SLOW, DIR_FWD, TURN_HARD_LEFT);
    if (ang > ANG_270 && ang <= ANG_353) return motor(SPD_SLOW, DIR_FWD, TURN_SLIGHT_LEFT);
    return motor(SPD_NORMAL, DIR_FWD, TURN_STRAIGHT);
  endfunction

  // apply one accepted request and queue the results it should produce
  task automatic advance_controller(evt_t e);
    result_t outs [$];
    result_t r;
    bit      path_clear;
    path_clear = 1'b0;
    case (e.cmd)
      CMD_TICK: begin
        if (avoid_on) begin
          if (avoid_command(r)) outs.push_back(r);
          else path_clear = 1'b1;
        end
        if (ctl_mode == MODE_NAV && path_clear) begin
          if (comp_dist <= reach_lim && target_idx < total_pts) begin
            ctl_mode = MODE_SEND;
          end else if (comp_dist <= final_lim && target_idx == total_pts) begin
            ctl_mode = MODE_STOP;
            avoid_on = 1'b0;
            outs.push_back(motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT));
          end
          outs.push_back(steer_command());
        end else if (ctl_mode == MODE_SEND) begin
          r = '0;
          r.kind = KIND_POINT;
          if (target_idx < MAX_WAYPOINTS) begin
            r.lat = lat_mem[target_idx];
            r.lon = lon_mem[target_idx];
          end
          outs.push_back(r);
        end else if (ctl_mode == MODE_STOP) begin
          outs.push_back(motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT));
        end
      end
      CMD_SONAR: begin
        son_mem[0] = e.son_l;
        son_mem[1] = e.son_c;
        son_mem[2] = e.son_r;
        son_mem[3] = e.son_b;
      end
      CMD_COUNT: begin
        total_pts = (e.point_cnt > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(e.point_cnt);
        fill_idx = 0;
        target_idx = 0;
      end
      CMD_WAYPOINT: begin
        // a full store drops the write entirely
        if (fill_idx < MAX_WAYPOINTS) begin
          lat_mem[fill_idx] = e.lat;
          lon_mem[fill_idx] = e.lon;
          fill_idx++;
          if (fill_idx == total_pts) ctl_mode = MODE_SEND;
        end
      end
      CMD_COMPASS: begin
        comp_dist = e.distance;
        comp_bear = e.bear;
        comp_head = e.head;
        if (ctl_mode == MODE_SEND) begin
          if (target_idx < MAX_WAYPOINTS) target_idx++;
          ctl_mode = MODE_NAV;
        end
      end
      CMD_START: avoid_on = 1'b1;
      CMD_STOP: begin
        ctl_mode = MODE_STOP;
        avoid_on = 1'b0;
        outs.push_back(motor(SPD_STOP, DIR_FWD, TURN_STRAIGHT));
      end
      default: ;
    endcase
    if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) due_results.push_back(outs[i]);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_event(evt_t e);
    return {3'b000, e.head, e.bear, e.distance, e.lon, e.lat, e.point_cnt,
            e.son_b, e.son_r, e.son_c, e.son_l};
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return ANGLE_W'(ANG_FULL - 1);
      default: return ANGLE_W'($urandom_range(ANG_FULL - 1, 0));
    endcase
  endfunction

  // every field random within its range; callers override what matters
  function automatic evt_t rand_event(logic [CMD_W-1:0] cmd);
    evt_t e;
    int   v;
    e.cmd = cmd;
    e.son_l = SONAR_W'($urandom_range(4095, 0));
    e.son_c = SONAR_W'($urandom_range(4095, 0));
    e.son_r = SONAR_W'($urandom_range(4095, 0));
    e.son_b = SONAR_W'($urandom_range(4095, 0));
    e.point_cnt = COUNT_W'($urandom_range(255, 0));
    v = ($urandom_range(7, 0) == 0) ? 900000000 : int'($urandom_range(900000000, 0));
    if ($urandom_range(1, 0) == 1) v = -v;
    e.lat = LAT_W'(v);
    v = ($urandom_range(7, 0) == 0) ? 1800000000 : int'($urandom_range(1800000000, 0));
    if ($urandom_range(1, 0) == 1) v = -v;
    e.lon = LON_W'(v);
    e.distance = DIST_W'($urandom_range(1048575, 0));
    e.bear = rand_angle();
    e.head = rand_angle();
    return e;
  endfunction

  function automatic evt_t sonar_evt(logic [SONAR_W-1:0] l, logic [SONAR_W-1:0] c,
                                     logic [SONAR_W-1:0] r, logic [SONAR_W-1:0] b);
    evt_t e;
    e = rand_event(CMD_SONAR);
    e.son_l = l;
    e.son_c = c;
    e.son_r = r;
    e.son_b = b;
    return e;
  endfunction

  function automatic evt_t compass_evt(logic [DIST_W-1:0] d, logic [ANGLE_W-1:0] b,
                                       logic [ANGLE_W-1:0] h);
    evt_t e;
    e = rand_event(CMD_COMPASS);
    e.distance = d;
    e.bear = b;
    e.head = h;
    return e;
  endfunction

  // mostly clear readings, plus values around the range bounds
  function automatic logic [SONAR_W-1:0] rand_sonar();
    logic [SONAR_W-1:0] lim;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: return SONAR_W'($urandom_range(4095, 400));
      5, 6: return SONAR_W'($urandom_range(4095, 0));
      default: begin
        case ($urandom_range(4, 0))
          0: lim = vnear_lim;
          1: lim = near_lim;
          2: lim = side_lim;
          3: lim = center_lim;
          default: lim = rear_lim;
        endcase
        return lim + SONAR_W'($urandom_range(2, 0)) - SONAR_W'(1);
      end
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return reach_lim;
      2: return reach_lim + DIST_W'(1);
      3: return final_lim;
      4: return final_lim + DIST_W'(1);
      5, 6: return DIST_W'($urandom_range(64, 0));
      default: return DIST_W'($urandom_range(1048575, 0));
    endcase
  endfunction

  task automatic queue_event(evt_t e);
    event_queue.push_back(e);
    if (e.cmd != CMD_UNUSED) total_queued++;
  endtask

  // one waypoint run: count, data, a start in most runs, then a random mix of events
  task automatic add_mission();
    int   n, writes, steps, pick;
    evt_t e;
    n = ($urandom_range(7, 0) == 0) ? int'($urandom_range(255, 0)) : int'($urandom_range(4, 1));
    e = rand_event(CMD_COUNT);
    e.point_cnt = COUNT_W'(n);
    queue_event(e);
    writes = (n > MAX_WAYPOINTS) ? MAX_WAYPOINTS : n;
    case ($urandom_range(9, 0))
      0: if (writes > 0) writes--;
      1: writes += 2;
      default: ;
    endcase
    repeat (writes) queue_event(rand_event(CMD_WAYPOINT));
    if ($urandom_range(9, 0) != 0) queue_event(rand_event(CMD_START));
    steps = $urandom_range(40, 8);
    repeat (steps) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) e = rand_event(CMD_TICK);
      else if (pick < 65) e = sonar_evt(rand_sonar(), rand_sonar(), rand_sonar(), rand_sonar());
      else if (pick < 90) e = compass_evt(rand_dist(), rand_angle(), rand_angle());
      else if (pick < 93) e = rand_event(CMD_START);
      else if (pick < 95) e = rand_event(CMD_STOP);
      else if (pick < 97) e = rand_event(CMD_WAYPOINT);
      else e = rand_event(CMD_UNUSED);
      queue_event(e);
    end
  endtask

  task automatic add_random(int n);
    int start;
    start = total_queued;
    while (total_queued - start < n) begin
      if ($urandom_range(9, 0) == 0) queue_event(rand_event(CMD_W'($urandom_range(7, 0))));
      else add_mission();
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VERY_NEAR:  vnear_lim = val[SONAR_W-1:0];
      CFG_NEAR:       near_lim = val[SONAR_W-1:0];
      CFG_SIDE_MED:   side_lim = val[SONAR_W-1:0];
      CFG_CENTER_MED: center_lim = val[SONAR_W-1:0];
      CFG_REAR_MED:   rear_lim = val[SONAR_W-1:0];
      CFG_REACH_DIST: reach_lim = val;
      CFG_FINAL_STOP: final_lim = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(int vn, int nr, int sd, int ct, int rr, int reach, int fin);
    write_reg(CFG_VERY_NEAR, CFG_DATA_W'(vn));
    write_reg(CFG_NEAR, CFG_DATA_W'(nr));
    write_reg(CFG_SIDE_MED, CFG_DATA_W'(sd));
    write_reg(CFG_CENTER_MED, CFG_DATA_W'(ct));
    write_reg(CFG_REAR_MED, CFG_DATA_W'(rr));
    write_reg(CFG_REACH_DIST, CFG_DATA_W'(reach));
    write_reg(CFG_FINAL_STOP, CFG_DATA_W'(fin));
  endtask

  // wait for the stimulus to go out and every expected result to come back
  task automatic drain();
    do @(posedge clk);
    while (event_queue.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_controller(cur_evt);
      if (!in_tvalid || in_tready) begin
        if (event_queue.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
          cur_evt = event_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= pack_event(cur_evt);
          in_tuser <= cur_evt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_req) begin
      hold_left <= HOLD_CYCLES;
      hold_off_req <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.kind = out_tuser;
      got_res.speed = speed_e'(out_tdata[1:0]);
      got_res.dir = dir_e'(out_tdata[2]);
      got_res.turn = turn_e'(out_tdata[5:3]);
      got_res.lat = out_tdata[36:6];
      got_res.lon = out_tdata[68:37];
      got_res.last = out_tlast;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("cycle %0d: unexpected result kind %0d speed %0d turn %0d", cycle_count,
                   got_res.kind, got_res.speed, got_res.turn);
        mismatches++;
      end else begin
        want_res = due_results.pop_front();
        if (got_res != want_res) begin
          if (mismatches < 10) begin
            $display("cycle %0d: expected kind %0d speed %0d dir %0d turn %0d lat %h lon %h last %0d",
                     cycle_count, want_res.kind, want_res.speed, want_res.dir, want_res.turn,
                     want_res.lat, want_res.lon, want_res.last);
            $display("          got      kind %0d speed %0d dir %0d turn %0d lat %h lon %h last %0d",
                     got_res.kind, got_res.speed, got_res.dir, got_res.turn,
                     got_res.lat, got_res.lon, got_res.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rover_obstacle_and_waypoint_controller verification failed");
      $finish;
    end
  end

  initial begin
    evt_t e;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset limits, one short mission through every mode
    queue_event(rand_event(CMD_UNUSED));
    queue_event(sonar_evt(12'd4095, 12'd4095, 12'd4095, 12'd4095));
    queue_event(rand_event(CMD_START));
    e = rand_event(CMD_COUNT);
    e.point_cnt = 8'd2;
    queue_event(e);
    e = rand_event(CMD_WAYPOINT);
    e.lat = LAT_W'(900000000);
    e.lon = LON_W'(-1800000000);
    queue_event(e);
    e = rand_event(CMD_WAYPOINT);
    e.lat = LAT_W'(-900000000);
    e.lon = LON_W'(1800000000);
    queue_event(e);
    queue_event(rand_event(CMD_TICK));
    queue_event(compass_evt(20'hFFFFF, 13'd5759, 13'd0));
    // very near readings fall through every near test
    queue_event(sonar_evt(12'd5, 12'd4095, 12'd4095, 12'd0));
    queue_event(rand_event(CMD_TICK));
    queue_event(sonar_evt(12'd4095, 12'd60, 12'd4095, 12'd100));
    queue_event(rand_event(CMD_TICK));
    queue_event(sonar_evt(12'd50, 12'd4095, 12'd60, 12'd101));
    queue_event(rand_event(CMD_TICK));
    queue_event(compass_evt(20'd48, 13'd0, 13'd1));
    queue_event(sonar_evt(12'd4095, 12'd4095, 12'd4095, 12'd4095));
    queue_event(rand_event(CMD_TICK));
    queue_event(sonar_evt(12'd100, 12'd4095, 12'd4095, 12'd4095));
    queue_event(rand_event(CMD_TICK));
    queue_event(sonar_evt(12'd4095, 12'd4095, 12'd4095, 12'd4095));
    queue_event(compass_evt(20'd32, 13'd1440, 13'd0));
    queue_event(rand_event(CMD_TICK));
    queue_event(rand_event(CMD_TICK));
    queue_event(rand_event(CMD_STOP));
    e = rand_event(CMD_COUNT);
    e.point_cnt = 8'd255;
    queue_event(e);
    drain();

    set_limits($urandom_range(20, 0), $urandom_range(90, 30), $urandom_range(200, 100),
               $urandom_range(250, 100), $urandom_range(200, 80), $urandom_range(200, 16),
               $urandom_range(100, 0));
    add_random(350);
    drain();

    send_idle = 75;
    recv_idle = 8;
    set_limits(0, 4095, 0, 0, 0, 0, 1048575);
    add_random(250);
    drain();

    set_limits(4095, 4095, 4095, 4095, 4095, 1048575, 1048575);
    add_random(200);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_limits(5, 60, 120, 140, 100, 48, 32);
    add_random(550);
    // sink stalls long enough for the request queue to back up
    hold_off_req <= 1'b1;
    drain();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("rover_obstacle_and_waypoint_controller verification clean");
    end else begin
      $display("rover_obstacle_and_waypoint_controller verification failed");
    end
    $finish;
  end

endmodule
